[hw/rtl/sdss_pkg.sv]
// Shared types and constants for the stable descending score sorter.
package sdss_pkg;

	localparam int CAPACITY_DEF = 256;
	localparam int SCORE_W      = 32;
	localparam int MOVE_W       = 16;
	localparam int TDATA_W      = 48;

	typedef enum logic {
		OP_APPEND = 1'b0,
		OP_POP    = 1'b1
	} opcode_t;

	// One stored entry
	typedef struct packed {
		logic signed [SCORE_W-1:0] score;
		logic [MOVE_W-1:0]         move;
	} entry_t;

	// Per-cycle command broadcast to every cell
	typedef struct packed {
		logic ins;
		logic pop;
	} cell_cmd_t;

endpackage

[hw/rtl/stable_descending_score_sorter.sv]
// Top level of the stable descending score sorter: cell row, count, flag and output register.
//
//  channel | dir | handshake          | payload
//  s       | in  | s_tvalid/s_tready  | s_tdata: entry_score, entry_move; s_tuser: opcode
//  m       | out | m_tvalid/m_tready  | m_tdata: out_move, out_score; m_tlast: is_last;
//          |     |                    | m_tuser: was_empty, overflowed
//
// All CAPACITY cells compare against the new entry in parallel and shift by one
// place in the same cycle that the transaction is accepted.
// A pop result appears on m in the cycle after its transaction is accepted.
// s_tready drops only while a pop result waits in the output register.
// Reset empties the store at once (count and overflow flag cleared).
module stable_descending_score_sorter import sdss_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [TDATA_W-1:0] s_tdata,   // [31:0] entry_score, [47:32] entry_move
	input  logic               s_tuser,   // [0] opcode
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata,   // [15:0] out_move, [47:16] out_score
	output logic               m_tlast,
	output logic [1:0]         m_tuser    // [0] was_empty, [1] overflowed
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
	localparam logic [CW-1:0] ONE_C = CW'(1);

	logic [CW-1:0] count_q;
	logic          ovf_q;
	logic          out_valid_q;
	entry_t        out_entry_q;
	logic          out_last_q;
	logic          out_empty_q;
	logic          out_ovf_q;

	logic          accept;
	opcode_t       op;
	entry_t        new_entry;
	cell_cmd_t     cmd;
	logic          is_full;
	logic          is_empty;
	logic [CAPACITY-1:0] take;
	entry_t        cells [CAPACITY];

	assign s_tready        = !out_valid_q || m_tready;
	assign accept          = s_tvalid && s_tready;
	assign op              = opcode_t'(s_tuser);
	assign new_entry.score = s_tdata[31:0];
	assign new_entry.move  = s_tdata[47:32];
	assign is_full         = count_q == CAP_C;
	assign is_empty        = count_q == '0;
	assign cmd.ins         = accept && (op == OP_APPEND) && !is_full;
	assign cmd.pop         = accept && (op == OP_POP) && !is_empty;

	// Row of cells, front (highest score) at index 0
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic   prev_take;
		entry_t prev_entry;
		entry_t next_entry;
		if (i == 0) begin : g_head
			assign prev_take  = 1'b0;
			assign prev_entry = cells[i];
		end else begin : g_body
			assign prev_take  = take[i-1];
			assign prev_entry = cells[i-1];
		end
		if (i == CAPACITY - 1) begin : g_tail
			assign next_entry = cells[i];
		end else begin : g_inner
			assign next_entry = cells[i+1];
		end
		sdss_cell #(
			.IDX (i),
			.CW  (CW)
		) u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.count      (count_q),
			.new_entry  (new_entry),
			.prev_take  (prev_take),
			.prev_entry (prev_entry),
			.next_entry (next_entry),
			.take       (take[i]),
			.entry      (cells[i])
		);
	end

	// Track fill level and the sticky overflow flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (accept) begin
			if (op == OP_APPEND) begin
				if (is_full) begin
					ovf_q <= 1'b1;
				end else begin
					count_q <= count_q + ONE_C;
				end
			end else begin
				if (!is_empty) begin
					count_q <= count_q - ONE_C;
				end
				if (is_empty || count_q == ONE_C) begin
					ovf_q <= 1'b0;
				end
			end
		end
	end

	// Hold a pop result until the downstream side takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && op == OP_POP) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Capture the front entry and status on pop
	always_ff @(posedge clk) begin
		if (accept && op == OP_POP) begin
			out_ovf_q   <= ovf_q;
			out_empty_q <= is_empty;
			out_last_q  <= count_q == ONE_C;
			if (is_empty) begin
				out_entry_q <= '0;
			end else begin
				out_entry_q <= cells[0];
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_entry_q.score, out_entry_q.move};
	assign m_tlast  = out_last_q;
	assign m_tuser  = {out_ovf_q, out_empty_q};

endmodule

[hw/rtl/sdss_cell.sv]
// One slot of the sorted store: compare with the new entry, then hold, load or shift.
module sdss_cell import sdss_pkg::*; #(
	parameter int IDX = 0,
	parameter int CW  = 9
) (
	input  logic          clk,
	input  cell_cmd_t     cmd,
	input  logic [CW-1:0] count,
	input  entry_t        new_entry,
	input  logic          prev_take,
	input  entry_t        prev_entry,
	input  entry_t        next_entry,
	output logic          take,
	output entry_t        entry
);

	localparam logic [CW-1:0] IDX_C = CW'(IDX);

	entry_t entry_q;
	logic   occupied;
	logic   beats;

	// New entry goes ahead of this one only on a strictly greater score
	assign occupied = IDX_C < count;
	assign beats    = occupied && ($signed(new_entry.score) > $signed(entry_q.score));
	assign take     = beats || (count == IDX_C);
	assign entry    = entry_q;

	// Load the new entry at the insert point, shift down behind it, shift up on pop
	always_ff @(posedge clk) begin
		if (cmd.pop) begin
			entry_q <= next_entry;
		end else if (cmd.ins && take) begin
			if (prev_take) begin
				entry_q <= prev_entry;
			end else begin
				entry_q <= new_entry;
			end
		end
	end

endmodule

[verif/sdss_sorter_scoreboard.sv]
// Scoreboard class that predicts the sorter's store and checks every pop result.
package sdss_sorter_sb_pkg;
	import sdss_pkg::*;

	// Fields of one pop result as the m side carries them
	typedef struct packed {
		logic [MOVE_W-1:0]         move;
		logic signed [SCORE_W-1:0] score;
		logic                      is_last;
		logic                      was_empty;
		logic                      overflowed;
	} pop_result_t;

	class sorter_scoreboard;
		int unsigned depth;
		entry_t      ranked[$];       // predicted store, highest score at the front
		bit          overflow_seen;   // predicted sticky overflow flag
		pop_result_t pending_pops[$]; // pop results still to arrive, oldest first
		int unsigned errors;
		int unsigned n_appends;
		int unsigned n_dropped;
		int unsigned n_pops;
		int unsigned n_empty_pops;
		int unsigned n_checked;

		function new(int unsigned cap);
			depth = cap;
		endfunction

		function int unsigned occupancy();
			return ranked.size();
		endfunction

		function int unsigned outstanding();
			return pending_pops.size();
		endfunction

		// Advance the predicted store by one accepted transaction
		function void note_input(opcode_t op, logic signed [SCORE_W-1:0] score,
				logic [MOVE_W-1:0] move);
			int unsigned pos;
			entry_t      e;
			pop_result_t r;
			if (op == OP_APPEND) begin
				n_appends++;
				if (ranked.size() >= depth) begin
					// full store: drop the entry and remember it
					overflow_seen = 1'b1;
					n_dropped++;
				end else begin
					// go behind every entry with an equal or higher score
					pos = ranked.size();
					while (pos > 0 && $signed(score) > $signed(ranked[pos-1].score))
						pos--;
					e.score = score;
					e.move  = move;
					ranked.insert(pos, e);
				end
			end else begin
				n_pops++;
				r = '0;
				r.overflowed = overflow_seen;
				if (ranked.size() == 0) begin
					r.was_empty   = 1'b1;
					overflow_seen = 1'b0;
					n_empty_pops++;
				end else begin
					e = ranked.pop_front();
					r.move  = e.move;
					r.score = e.score;
					if (ranked.size() == 0) begin
						r.is_last     = 1'b1;
						overflow_seen = 1'b0;
					end
				end
				pending_pops.insert(pending_pops.size(), r);
			end
		endfunction

		// Print one line per mismatch; keep the log bounded
		task report(string msg);
			errors++;
			if (errors <= 100)
				$display("ERROR at %0t: %s", $time, msg);
		endtask

		// Compare one accepted pop result with the oldest prediction
		task check_pop(pop_result_t got);
			pop_result_t want;
			if (pending_pops.size() == 0) begin
				report($sformatf("pop result with nothing pending: move 0x%h score %0d",
					got.move, got.score));
				return;
			end
			want = pending_pops.pop_front();
			n_checked++;
			if (got.move !== want.move)
				report($sformatf("pop %0d out_move 0x%h, predicted 0x%h",
					n_checked, got.move, want.move));
			if (got.score !== want.score)
				report($sformatf("pop %0d out_score %0d, predicted %0d",
					n_checked, got.score, want.score));
			if (got.is_last !== want.is_last)
				report($sformatf("pop %0d is_last %b, predicted %b",
					n_checked, got.is_last, want.is_last));
			if (got.was_empty !== want.was_empty)
				report($sformatf("pop %0d was_empty %b, predicted %b",
					n_checked, got.was_empty, want.was_empty));
			if (got.overflowed !== want.overflowed)
				report($sformatf("pop %0d overflowed %b, predicted %b",
					n_checked, got.overflowed, want.overflowed));
		endtask
	endclass

endpackage

[verif/tb_top.sv]
// Top-level testbench: drives append and pop transactions into the sorter and checks pops.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import sdss_pkg::*;
	import sdss_sorter_sb_pkg::*;

	localparam int unsigned DEPTH        = CAPACITY_DEF;
	localparam int unsigned ITEM_TARGET  = 1500;
	localparam int unsigned MAX_GAP      = 10;
	localparam int unsigned PRESSURE_AT  = 30;
	localparam int unsigned PRESSURE_LEN = 250;
	localparam int unsigned CYCLE_LIMIT  = 400000;

	logic               clk      = 1'b0;
	logic               arst_n   = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [TDATA_W-1:0] s_tdata  = '0;
	logic               s_tuser  = OP_APPEND;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [TDATA_W-1:0] m_tdata;
	logic               m_tlast;
	logic [1:0]         m_tuser;

	sorter_scoreboard sb;
	pop_result_t      seen;
	int unsigned      tx_max_gap = 0;
	int unsigned      n_items    = 0;
	int unsigned      cycles     = 0;

	stable_descending_score_sorter i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),   // [31:0] entry_score, [47:32] entry_move
		.s_tuser  (s_tuser),   // [0] opcode
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),   // [15:0] out_move, [47:16] out_score
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)    // [0] was_empty, [1] overflowed
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Offer one transaction after a random gap and hold it until accepted
	task automatic send(opcode_t op, logic signed [SCORE_W-1:0] score,
			logic [MOVE_W-1:0] move);
		int unsigned gap;
		gap = (tx_max_gap == 0) ? 0 : $urandom_range(0, tx_max_gap);
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tdata  = {move, score};
		s_tuser  = op;
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		sb.note_input(op, score, move);
		n_items++;
	endtask

	// Pop with random contents in the ignored fields
	task automatic pop_one();
		send(OP_POP, $urandom, MOVE_W'($urandom));
	endtask

	// Mix of ties, extremes and full-range scores
	function automatic logic signed [SCORE_W-1:0] draw_score();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 6) - 3;
			1: begin
				case ($urandom_range(0, 3))
					0: return 32'h7FFF_FFFF;
					1: return 32'h8000_0000;
					2: return 32'h0000_0000;
					default: return 32'hFFFF_FFFF;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	// Fill the store, push a few more past capacity, then drain past empty
	task automatic fill_and_drain();
		int unsigned extra;
		extra = $urandom_range(1, 5);
		while (sb.occupancy() < DEPTH)
			send(OP_APPEND, draw_score(), MOVE_W'($urandom));
		repeat (extra) send(OP_APPEND, draw_score(), MOVE_W'($urandom));
		while (sb.occupancy() > 0)
			pop_one();
		pop_one();
	endtask

	// Load a short list, then pop it all and a little more
	task automatic build_and_drain(int unsigned n);
		repeat (n) send(OP_APPEND, draw_score(), MOVE_W'($urandom));
		repeat (n + $urandom_range(1, 3)) pop_one();
	endtask

	// Random interleave of appends and pops
	task automatic mixed_run(int unsigned len, int unsigned append_pct);
		repeat (len) begin
			if ($urandom_range(1, 100) <= append_pct)
				send(OP_APPEND, draw_score(), MOVE_W'($urandom));
			else
				pop_one();
		end
	endtask

	// Stimulus
	initial begin
		int unsigned kind;
		int unsigned fills;
		sb = new(DEPTH);
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// directed: empty pop, extremes, ties in arrival order, alternating bits
		pop_one();
		send(OP_APPEND, 32'h7FFF_FFFF, 16'hFFFF);
		send(OP_APPEND, 32'h8000_0000, 16'h0000);
		send(OP_APPEND, 32'h0000_0000, 16'h0001);
		send(OP_APPEND, 32'hFFFF_FFFF, 16'h0002);
		send(OP_APPEND, 32'h0000_0000, 16'h0003);
		send(OP_APPEND, 32'h7FFF_FFFF, 16'h0004);
		send(OP_APPEND, 32'h8000_0000, 16'h0005);
		send(OP_APPEND, 32'h5555_5555, 16'hAAAA);
		send(OP_APPEND, 32'hAAAA_AAAA, 16'h5555);
		repeat (9) pop_one();
		pop_one();

		// random part, starting with one pass over capacity
		tx_max_gap = MAX_GAP;
		fill_and_drain();
		fills = 1;
		while (n_items < ITEM_TARGET) begin
			tx_max_gap = ($urandom_range(0, 2) == 0) ? 0 : MAX_GAP;
			kind = $urandom_range(0, 9);
			if (kind == 9 && fills < 2 && n_items < ITEM_TARGET / 2) begin
				fill_and_drain();
				fills++;
			end else if (kind >= 6) begin
				build_and_drain($urandom_range(1, 40));
			end else begin
				mixed_run($urandom_range(20, 80), $urandom_range(40, 75));
			end
		end
		@(negedge clk);
		s_tvalid = 1'b0;

		// drain outstanding pops, then let the output register settle
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (5) @(posedge clk);
		$display("Run covered %0d transactions: %0d appends (%0d dropped while full), %0d pops",
			n_items, sb.n_appends, sb.n_dropped, sb.n_pops);
		$display("%0d pop results checked, %0d of them on an empty store",
			sb.n_checked, sb.n_empty_pops);
		if (sb.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Receiver: random stalls, stretches without stalls, one long hold-off
	initial begin
		int unsigned wait_cycles;
		int unsigned got;
		int unsigned rx_max_gap;
		bit          pressured;
		got        = 0;
		rx_max_gap = 0;
		pressured  = 1'b0;
		@(posedge arst_n);
		forever begin
			if (got % 32 == 0)
				rx_max_gap = ($urandom_range(0, 2) == 0) ? 0 : MAX_GAP;
			wait_cycles = (rx_max_gap == 0) ? 0 : $urandom_range(0, rx_max_gap);
			if (got == PRESSURE_AT && !pressured) begin
				wait_cycles = PRESSURE_LEN;
				pressured   = 1'b1;
			end
			@(negedge clk);
			if (wait_cycles > 0) begin
				m_tready = 1'b0;
				repeat (wait_cycles) @(negedge clk);
			end
			m_tready = 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready));
			got++;
		end
	end

	// Check each accepted pop result
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			seen.move       = m_tdata[MOVE_W-1:0];
			seen.score      = m_tdata[TDATA_W-1:MOVE_W];
			seen.is_last    = m_tlast;
			seen.was_empty  = m_tuser[0];
			seen.overflowed = m_tuser[1];
			sb.check_pop(seen);
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d pops outstanding", cycles, sb.outstanding());
			$display("Mismatches found");
			$finish;
		end
	end

endmodule

[filelist.f]
hw/rtl/sdss_pkg.sv
hw/rtl/sdss_cell.sv
hw/rtl/stable_descending_score_sorter.sv
verif/sdss_sorter_scoreboard.sv
verif/tb_top.sv
